// ===== rtl/ffpa_pkg.sv =====
// Shared constants, codes and types of the first-fit partition allocator.
`timescale 1ns / 1ps

package ffpa_pkg;

  // Table geometry
  localparam int NUM_SLOTS = 16;   // 2 .. 16
  localparam int SIZE_BITS = 16;   // 8 .. 32
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Fixed field widths on the stream ports
  localparam int IDX_W  = 4;
  localparam int AMT_W  = 16;
  localparam int STAT_W = 2;
  localparam int IN_DATA_W  = 24;  // slot_index + amount_kb, padded to bytes
  localparam int OUT_DATA_W = 24;  // granted_slot + leftover_kb, padded

  // Item kinds (in_tuser)
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Result status codes (out_tuser)
  localparam logic [STAT_W-1:0] ST_LOADED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_GRANTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd2;

  // One result beat
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  slot;
    logic [AMT_W-1:0]  left;
  } result_t;

endpackage

// ===== rtl/first_fit_partition_allocator_unit.sv =====
// Top level of the first-fit fixed partition allocator.
`timescale 1ns / 1ps

// A load beat writes one partition size, marks the partition loaded and free,
// and yields a "loaded" result, which passes the result register and then the
// output register; an index beyond the table writes nothing but still yields
// that result. An allocate beat scans partitions from index 0 upward,
// reading one size per cycle from the size memory (one read port, registered
// read data), and grants the first loaded, free partition that is large
// enough, or reports no fit after the last partition. One item is worked on
// at a time; a new beat is taken as soon as the previous result has left the
// work stage, even while that result still waits in the output register.
module first_fit_partition_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // slave side
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ffpa_pkg::IN_DATA_W-1:0] in_tdata,   // [3:0] slot_index, [19:4] amount_kb
  input  logic [0:0]                     in_tuser,   // [0] operation
  // master side
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ffpa_pkg::OUT_DATA_W-1:0] out_tdata, // [3:0] granted_slot, [19:4] leftover_kb
  output logic [ffpa_pkg::STAT_W-1:0]    out_tuser   // [1:0] status
);

  import ffpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t              st_r, st_nxt;
  logic [SLOT_W-1:0]   iss_r, iss_nxt;       // read address being issued
  logic [SLOT_W-1:0]   chk_idx_r, chk_idx_nxt; // index whose size is on rd_data
  logic                chk_v_r, chk_v_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  result_t             res_r, res_nxt;
  logic [NUM_SLOTS-1:0] loaded_r, loaded_nxt;
  logic [NUM_SLOTS-1:0] taken_r, taken_nxt;
  logic                out_v_r, out_v_nxt;
  result_t             out_r, out_nxt;

  logic                 in_beat;
  logic [IDX_W-1:0]     in_idx;
  logic [AMT_W-1:0]     in_amt;
  logic [47:0]          amt_wide;
  logic [SIZE_BITS-1:0] amt_s;
  logic [31:0]          idx_wide;
  logic                 idx_ok;
  logic [SLOT_W-1:0]    wr_idx;
  logic                 ram_we;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 fit;
  logic                 last;
  logic [SIZE_BITS-1:0] diff;
  logic [47:0]          diff_wide;
  logic [31:0]          chk_wide;
  logic                 out_free;

  // Input field decode
  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_amt   = in_tdata[IDX_W+AMT_W-1:IDX_W];
  assign amt_wide = 48'(in_amt);
  assign amt_s    = amt_wide[SIZE_BITS-1:0];
  assign idx_wide = 32'(in_idx);
  assign idx_ok   = idx_wide < 32'(NUM_SLOTS);
  assign wr_idx   = idx_wide[SLOT_W-1:0];

  assign in_tready = (st_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign ram_we    = in_beat && (in_tuser[0] == OP_LOAD) && idx_ok;

  // Partition size memory
  ffpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (amt_s),
    .raddr (iss_r),
    .rdata (rd_data)
  );

  // Fit check on the size returned by the memory
  assign fit  = chk_v_r && loaded_r[chk_idx_r] && !taken_r[chk_idx_r] && (rd_data >= req_r);
  assign last = chk_v_r && (chk_idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign diff      = rd_data - req_r;
  assign diff_wide = 48'(diff);
  assign chk_wide  = 32'(chk_idx_r);

  assign out_free = !out_v_r || out_tready;

  // Control and flag update
  always_comb begin
    st_nxt      = st_r;
    iss_nxt     = iss_r;
    chk_idx_nxt = iss_r;
    chk_v_nxt   = 1'b0;
    req_nxt     = req_r;
    res_nxt     = res_r;
    loaded_nxt  = loaded_r;
    taken_nxt   = taken_r;
    out_v_nxt   = out_v_r && !out_tready;
    out_nxt     = out_r;

    case (st_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_tuser[0] == OP_LOAD) begin
            if (idx_ok) begin
              loaded_nxt[wr_idx] = 1'b1;
              taken_nxt[wr_idx]  = 1'b0;
            end
            res_nxt = '{status: ST_LOADED, slot: '0, left: '0};
            st_nxt  = S_PUSH;
          end else begin
            req_nxt = amt_s;
            iss_nxt = '0;
            st_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_r != SLOT_W'(NUM_SLOTS - 1)) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (fit) begin
          taken_nxt[chk_idx_r] = 1'b1;
          res_nxt = '{status: ST_GRANTED, slot: chk_wide[IDX_W-1:0],
                      left: diff_wide[AMT_W-1:0]};
          st_nxt  = S_PUSH;
        end else if (last) begin
          res_nxt = '{status: ST_NOFIT, slot: '0, left: '0};
          st_nxt  = S_PUSH;
        end else begin
          chk_v_nxt = 1'b1;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_nxt   = res_r;
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      chk_v_r  <= 1'b0;
      loaded_r <= '0;
      taken_r  <= '0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      chk_v_r  <= chk_v_nxt;
      loaded_r <= loaded_nxt;
      taken_r  <= taken_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    iss_r     <= iss_nxt;
    chk_idx_r <= chk_idx_nxt;
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // Output beat
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = OUT_DATA_W'({out_r.left, out_r.slot});

  // Checks
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r == S_PUSH))
    else $error("output beat appeared without a finished result");

  a_alloc_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_tuser[0] == OP_ALLOC)) |=> (st_r == S_SCAN) && !chk_v_r)
    else $error("allocate beat did not start a fresh scan");

  a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_GRANTED)) |-> (32'(out_tdata[IDX_W-1:0]) < 32'(NUM_SLOTS)))
    else $error("granted slot beyond table");

  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN && fit) |=> taken_r[$past(chk_idx_r)] && (st_r == S_PUSH))
    else $error("granted partition not marked taken");

endmodule

// ===== rtl/ffpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module ffpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
